>>> design/bmos_pkg.sv
// ----------------------------------------------------------------------------
// bmos_pkg
// Shared types, codes and the command decoder for the bracket matching
// opcode stream.
// ----------------------------------------------------------------------------
package bmos_pkg;

    localparam int MAX_PROGRAM_DEF = 65536;
    localparam int MAX_NESTING_DEF = 256;

    // source characters of the eight commands
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;

    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_LEFT  = 3'd3;
    localparam logic [2:0] OP_OPEN  = 3'd4;
    localparam logic [2:0] OP_CLOSE = 3'd5;
    localparam logic [2:0] OP_OUT   = 3'd6;
    localparam logic [2:0] OP_IN    = 3'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_DEEP      = 2'd2;
    localparam logic [1:0] ERR_LONG      = 2'd3;

    typedef struct packed {
        logic       is_cmd;
        logic [2:0] op;
    } t_decode;

    // stack shift controls, same for every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] position;
        logic [15:0] partner;
        logic [1:0]  error_code;
    } t_out_item;

    function automatic t_decode decode_char(input logic [7:0] ch);
        t_decode d;
        d.is_cmd = 1'b1;
        d.op     = OP_PLUS;
        unique case (ch)
            CH_PLUS:  d.op = OP_PLUS;
            CH_MINUS: d.op = OP_MINUS;
            CH_RIGHT: d.op = OP_RIGHT;
            CH_LEFT:  d.op = OP_LEFT;
            CH_OPEN:  d.op = OP_OPEN;
            CH_CLOSE: d.op = OP_CLOSE;
            CH_OUT:   d.op = OP_OUT;
            CH_IN:    d.op = OP_IN;
            default:  d.is_cmd = 1'b0;
        endcase
        return d;
    endfunction

endpackage

>>> design/bmos_if.sv
// ----------------------------------------------------------------------------
// bmos_in_if / bmos_out_if
// Valid/ready channels for source characters and decoded commands.
// ----------------------------------------------------------------------------
interface bmos_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_final;

    modport source (output valid, output char_code, output is_final, input ready);
    modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface bmos_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] position;
    logic [15:0] partner;
    logic [1:0]  error_code;

    modport source (output valid, output opcode, output position, output partner,
                    output error_code, input ready);
    modport sink   (input valid, input opcode, input position, input partner,
                    input error_code, output ready);
endinterface

>>> design/bracket_matching_opcode_stream.sv
// ----------------------------------------------------------------------------
// bracket_matching_opcode_stream
// A command is registered into the output buffer on its input transfer.
// Throughput: one character per cycle while the skid slot is empty; the stack
// is a row of shifting cells, so push and pop finish in the cycle of the transfer.
// Reset (synchronous, active low) clears count, level, error and the output
// buffer; stack cells are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module bracket_matching_opcode_stream #(
    parameter int MAX_PROGRAM = bmos_pkg::MAX_PROGRAM_DEF,
    parameter int MAX_NESTING = bmos_pkg::MAX_NESTING_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmos_in_if.sink      i_in_ch,
    bmos_out_if.source   o_out_ch
);
    import bmos_pkg::*;

    localparam int CW = $clog2(MAX_PROGRAM + 1);
    localparam int PW = $clog2(MAX_PROGRAM);
    localparam int LW = $clog2(MAX_NESTING + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    logic [1:0]    r_err;
    logic [1:0]    n_err;

    logic          w_accept;
    logic          w_ready;
    t_decode       w_dec;
    logic          w_long;
    logic          w_full;
    logic          w_empty;
    logic          w_is_open;
    logic          w_is_close;
    logic [1:0]    w_new_err;
    logic [1:0]    w_err_out;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_partner;
    logic [PW+15:0] w_pos_ext;
    logic [PW+15:0] w_partner_ext;
    t_stk_ctl      w_ctl;
    t_out_item     w_item;
    logic          w_res_valid;
    logic [PW-1:0] w_cell [MAX_NESTING];

    assign i_in_ch.ready = w_ready;
    assign w_accept      = i_in_ch.valid & w_ready;
    assign w_dec         = decode_char(i_in_ch.char_code);

    assign w_long     = (r_count == CW'(MAX_PROGRAM));
    assign w_full     = (r_level == LW'(MAX_NESTING));
    assign w_empty    = (r_level == '0);
    assign w_is_open  = w_dec.is_cmd & (w_dec.op == OP_OPEN);
    assign w_is_close = w_dec.is_cmd & (w_dec.op == OP_CLOSE);

    assign w_pos = w_long ? PW'(MAX_PROGRAM - 1) : r_count[PW-1:0];

    assign w_ctl.push = w_accept & w_is_open & ~w_long & ~w_full;
    assign w_ctl.pop  = w_accept & w_is_close & ~w_long & ~w_empty;

    always_comb begin
        priority if (w_long) begin
            w_new_err = ERR_LONG;
        end else if (w_is_open && w_full) begin
            w_new_err = ERR_DEEP;
        end else if (w_is_close && w_empty) begin
            w_new_err = ERR_UNMATCHED;
        end else begin
            w_new_err = ERR_NONE;
        end
    end

    // first error wins
    assign w_err_out = (r_err != ERR_NONE) ? r_err : w_new_err;

    assign w_partner     = w_ctl.pop ? w_cell[0] : '0;
    assign w_pos_ext     = {16'b0, w_pos};
    assign w_partner_ext = {16'b0, w_partner};

    assign w_item.opcode     = w_dec.op;
    assign w_item.position   = w_pos_ext[15:0];
    assign w_item.partner    = w_partner_ext[15:0];
    assign w_item.error_code = w_err_out;
    assign w_res_valid       = w_accept & w_dec.is_cmd;

    always_comb begin
        n_count = r_count;
        n_level = r_level;
        n_err   = r_err;
        if (w_accept) begin
            if (i_in_ch.is_final) begin
                n_count = '0;
                n_level = '0;
                n_err   = ERR_NONE;
            end else if (w_dec.is_cmd) begin
                if (!w_long) begin
                    n_count = r_count + CW'(1);
                end
                if (w_ctl.push) begin
                    n_level = r_level + LW'(1);
                end else if (w_ctl.pop) begin
                    n_level = r_level - LW'(1);
                end
                n_err = w_err_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_level <= '0;
            r_err   <= ERR_NONE;
        end else begin
            r_count <= n_count;
            r_level <= n_level;
            r_err   <= n_err;
        end
    end

    // top of stack is cell 0
    for (genvar g = 0; g < MAX_NESTING; g++) begin : g_cell
        logic [PW-1:0] w_prev;
        logic [PW-1:0] w_next;
        if (g == 0) begin : g_head
            assign w_prev = w_pos;
        end else begin : g_body
            assign w_prev = w_cell[g-1];
        end
        if (g == MAX_NESTING - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_cell[g+1];
        end
        bmos_cell #(
            .W (PW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_prev (w_prev),
            .i_from_next (w_next),
            .o_data      (w_cell[g])
        );
    end

    bmos_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .i_item   (w_item),
        .o_ready  (w_ready),
        .o_out_ch (o_out_ch)
    );

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(MAX_NESTING))
        else $error("stack level beyond nesting limit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROGRAM))
        else $error("command count beyond program limit");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready && i_in_ch.is_final)
        |=> (r_count == '0 && r_level == '0 && r_err == ERR_NONE))
        else $error("state not cleared after final transfer");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ch.ready |-> o_out_ch.valid)
        else $error("input stalled with empty output register");

endmodule

>>> design/bmos_cell.sv
// ----------------------------------------------------------------------------
// bmos_cell
// One entry of the shifting open-bracket stack. Push takes the entry from the
// neighbor nearer the top, pop takes the one from the neighbor below.
// ----------------------------------------------------------------------------
module bmos_cell #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  bmos_pkg::t_stk_ctl    i_ctl,
    input  logic [W-1:0]          i_from_prev,
    input  logic [W-1:0]          i_from_next,
    output logic [W-1:0]          o_data
);
    import bmos_pkg::*;

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        priority if (i_ctl.push) begin
            n_data = i_from_prev;
        end else if (i_ctl.pop) begin
            n_data = i_from_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> design/bmos_skid.sv
// ----------------------------------------------------------------------------
// bmos_skid
// Output register with a skid slot, so the input side can deliver one more
// result while a result waits on the consumer.
// ----------------------------------------------------------------------------
module bmos_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bmos_pkg::t_out_item  i_item,
    output logic                 o_ready,
    bmos_out_if.source           o_out_ch
);
    import bmos_pkg::*;

    logic      r_main_v;
    logic      r_skid_v;
    t_out_item r_main;
    t_out_item r_skid;
    logic      w_take;

    assign w_take  = r_main_v & o_out_ch.ready;
    assign o_ready = ~r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // no new transfer can arrive while the skid slot is full
            if (w_take) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_main_v || w_take) begin
            r_main_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_main <= r_skid;
            end
        end else if (!r_main_v || w_take) begin
            r_main <= i_item;
        end else if (i_valid) begin
            r_skid <= i_item;
        end
    end

    assign o_out_ch.valid      = r_main_v;
    assign o_out_ch.opcode     = r_main.opcode;
    assign o_out_ch.position   = r_main.position;
    assign o_out_ch.partner    = r_main.partner;
    assign o_out_ch.error_code = r_main.error_code;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bracket_matching_opcode_stream. Source bytes are
// directed programs, short random programs (mostly balanced, some broken,
// some noise) and a full-depth nesting program. A local model of the command
// counter, bracket stack and sticky error predicts every command transfer;
// the output monitor checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
    import bmos_pkg::*;

    localparam int MAX_PROG     = MAX_PROGRAM_DEF;
    localparam int MAX_NEST     = MAX_NESTING_DEF;
    localparam int CYCLE_LIMIT  = 900_000;
    localparam int PRESSURE_AT  = 600;
    localparam int PRESSURE_LEN = 300;
    localparam int CALM_FROM    = 1000;
    localparam int CALM_TO      = 3000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_src_byte;

    logic clk;
    logic rst_n;

    bmos_in_if  src_ch ();
    bmos_out_if cmd_ch ();

    bracket_matching_opcode_stream dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (src_ch),
        .o_out_ch (cmd_ch)
    );

    t_src_byte  src_bytes[$];
    t_out_item  cmd_expect[$];
    t_src_byte  next_byte;
    t_out_item  next_cmd;
    int         cycle_count = 0;
    int         mismatches  = 0;
    int         hold_left   = 0;
    bit         byte_taken  = 1'b0;

    // predictor state
    logic [16:0] cmd_count  = '0;
    logic [15:0] open_pos [MAX_NEST];
    logic [8:0]  nest_level = '0;
    logic [1:0]  sticky_err = ERR_NONE;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n            = 1'b0;
        src_ch.valid     = 1'b0;
        src_ch.char_code = '0;
        src_ch.is_final  = 1'b0;
        cmd_ch.ready     = 1'b0;
    end

    always @(negedge clk) begin
        if (cycle_count >= 8) begin
            rst_n <= 1'b1;
        end
    end

    function automatic bit idle_roll();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 23;
    endfunction

    function automatic logic [7:0] plain_command();
        case ($urandom_range(0, 5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_RIGHT;
            3:       return CH_LEFT;
            4:       return CH_OUT;
            default: return CH_IN;
        endcase
    endfunction

    function automatic void push_src(logic [7:0] ch, logic fin);
        src_bytes.push_back('{ch: ch, fin: fin});
    endfunction

    // Returns 1 and fills cmd when the byte is a command.
    function automatic bit predict_command(t_src_byte b, output t_out_item cmd);
        logic [2:0]  op;
        logic [15:0] pos;
        logic [15:0] partner;
        bit          is_cmd;
        is_cmd  = 1'b1;
        op      = OP_PLUS;
        partner = '0;
        case (b.ch)
            CH_PLUS:  op = OP_PLUS;
            CH_MINUS: op = OP_MINUS;
            CH_RIGHT: op = OP_RIGHT;
            CH_LEFT:  op = OP_LEFT;
            CH_OPEN:  op = OP_OPEN;
            CH_CLOSE: op = OP_CLOSE;
            CH_OUT:   op = OP_OUT;
            CH_IN:    op = OP_IN;
            default:  is_cmd = 1'b0;
        endcase
        if (is_cmd) begin
            if (cmd_count >= MAX_PROG) begin
                // past the limit: count and stack frozen
                if (sticky_err == ERR_NONE) sticky_err = ERR_LONG;
                pos = 16'(MAX_PROG - 1);
            end else begin
                pos       = cmd_count[15:0];
                cmd_count = cmd_count + 1'b1;
                if (op == OP_OPEN) begin
                    if (nest_level >= MAX_NEST) begin
                        if (sticky_err == ERR_NONE) sticky_err = ERR_DEEP;
                    end else begin
                        open_pos[nest_level] = pos;
                        nest_level           = nest_level + 1'b1;
                    end
                end else if (op == OP_CLOSE) begin
                    if (nest_level == 0) begin
                        if (sticky_err == ERR_NONE) sticky_err = ERR_UNMATCHED;
                    end else begin
                        nest_level = nest_level - 1'b1;
                        partner    = open_pos[nest_level];
                    end
                end
            end
            cmd = '{opcode: op, position: pos, partner: partner, error_code: sticky_err};
        end
        if (b.fin) begin
            cmd_count  = '0;
            nest_level = '0;
            sticky_err = ERR_NONE;
        end
        return is_cmd;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Random program; brackets balanced up to depth_cap unless broken, though noise bytes may hold stray brackets.
    task automatic add_program(int n_cmds, int depth_cap, bit well_formed, bit mark_final);
        int         level;
        int         made;
        int         roll;
        logic [7:0] tail;
        level = 0;
        made  = 0;
        while (made < n_cmds) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                push_src(8'($urandom_range(0, 255)), 1'b0);
            end else if (roll < 28 && level < depth_cap) begin
                push_src(CH_OPEN, 1'b0);
                level++;
                made++;
            end else if (roll < 48 && level > 0) begin
                push_src(CH_CLOSE, 1'b0);
                level--;
                made++;
            end else begin
                push_src(plain_command(), 1'b0);
                made++;
            end
        end
        if (well_formed) begin
            repeat (level) push_src(CH_CLOSE, 1'b0);
        end else if ($urandom_range(0, 1) == 0) begin
            // one close too many
            repeat (level + 1) push_src(CH_CLOSE, 1'b0);
        end
        if (mark_final) begin
            if ($urandom_range(0, 3) == 0) begin
                do begin
                    tail = 8'($urandom_range(0, 255));
                end while (tail inside {CH_PLUS, CH_MINUS, CH_RIGHT, CH_LEFT,
                                        CH_OPEN, CH_CLOSE, CH_OUT, CH_IN});
                push_src(tail, 1'b1);
            end else begin
                src_bytes[src_bytes.size() - 1].fin = 1'b1;
            end
        end
    endtask

    task automatic add_random_programs(int n_bytes);
        int stop_at;
        stop_at = src_bytes.size() + n_bytes;
        while (src_bytes.size() < stop_at) begin
            if ($urandom_range(0, 19) == 0) begin
                push_src(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                add_program($urandom_range(1, 30), $urandom_range(1, 6),
                            $urandom_range(0, 99) < 80, 1'b1);
            end
        end
    endtask

    // source driver
    always @(negedge clk) begin
        if (!rst_n) begin
            src_ch.valid <= 1'b0;
        end else if (!src_ch.valid || byte_taken) begin
            if (src_bytes.size() != 0 && !idle_roll()) begin
                next_byte = src_bytes.pop_front();
                src_ch.valid     <= 1'b1;
                src_ch.char_code <= next_byte.ch;
                src_ch.is_final  <= next_byte.fin;
            end else begin
                src_ch.valid <= 1'b0;
            end
        end
    end

    // command receiver, with one long hold-off to back up the pipeline
    always @(negedge clk) begin
        if (!rst_n) begin
            cmd_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            cmd_ch.ready <= 1'b0;
        end else if (cycle_count == PRESSURE_AT) begin
            hold_left    <= PRESSURE_LEN;
            cmd_ch.ready <= 1'b0;
        end else begin
            cmd_ch.ready <= !idle_roll();
        end
    end

    // monitor: check output transfers, then predict from input transfers
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        byte_taken = 1'b0;
        if (rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                if (cmd_expect.size() == 0) begin
                    mismatches++;
                    $error("unexpected command: opcode %0d position %0d",
                           cmd_ch.opcode, cmd_ch.position);
                end else begin
                    next_cmd = cmd_expect.pop_front();
                    check_field("opcode", 16'(next_cmd.opcode), 16'(cmd_ch.opcode));
                    check_field("position", next_cmd.position, cmd_ch.position);
                    check_field("partner", next_cmd.partner, cmd_ch.partner);
                    check_field("error_code", 16'(next_cmd.error_code),
                                16'(cmd_ch.error_code));
                end
            end
            if (src_ch.valid && src_ch.ready) begin
                byte_taken = 1'b1;
                if (predict_command('{ch: src_ch.char_code, fin: src_ch.is_final},
                                    next_cmd)) begin
                    cmd_expect.push_back(next_cmd);
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("bracket_matching_opcode_stream: mismatch");
        $finish;
    end

    initial begin
        int drain;
        // unmatched close first; a later match keeps the first error
        push_src(CH_CLOSE, 1'b0);
        push_src(CH_OPEN, 1'b0);
        push_src(CH_CLOSE, 1'b0);
        push_src(CH_PLUS, 1'b1);
        // every command, with a dropped byte in the middle
        push_src(CH_PLUS, 1'b0);
        push_src(CH_MINUS, 1'b0);
        push_src(CH_RIGHT, 1'b0);
        push_src(8'hFF, 1'b0);
        push_src(CH_LEFT, 1'b0);
        push_src(CH_OPEN, 1'b0);
        push_src(CH_OUT, 1'b0);
        push_src(CH_IN, 1'b0);
        push_src(CH_CLOSE, 1'b1);
        // opens left unclosed at a final non-command byte, then an unmatched final close
        push_src(CH_OPEN, 1'b0);
        push_src(CH_OPEN, 1'b0);
        push_src(8'h00, 1'b1);
        push_src(CH_CLOSE, 1'b1);

        add_random_programs(390);

        // full-depth nesting, one open too many, then closes past empty
        for (int i = 0; i < MAX_NEST + 1; i++) begin
            push_src(CH_OPEN, 1'b0);
            if ($urandom_range(0, 7) == 0) push_src(plain_command(), 1'b0);
        end
        for (int i = 0; i < MAX_NEST + 2; i++) begin
            push_src(CH_CLOSE, 1'b0);
        end
        src_bytes[src_bytes.size() - 1].fin = 1'b1;

        add_random_programs(370);

        while (src_bytes.size() != 0 || src_ch.valid) @(posedge clk);
        for (drain = 0; drain < 1000 && cmd_expect.size() != 0; drain++) @(posedge clk);
        repeat (10) @(posedge clk);
        if (cmd_expect.size() != 0) begin
            mismatches++;
            $error("%0d expected commands never arrived", cmd_expect.size());
        end
        if (mismatches == 0) begin
            $display("bracket_matching_opcode_stream: match");
        end else begin
            $display("bracket_matching_opcode_stream: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/bmos_pkg.sv
design/bmos_if.sv
design/bmos_cell.sv
design/bmos_skid.sv
design/bracket_matching_opcode_stream.sv
tb/tb_top.sv
